// ----- rtl/pfc_pkg.sv -----
// Shared types, constants and helper functions of the Playfair pair cipher.
package pfc_pkg;

    localparam int SIDE      = 5;
    localparam int CELLS     = 25;
    localparam int LETTERS   = 26;
    localparam int LETTER_W  = 5;
    localparam int CELL_W    = 5;
    localparam int COORD_W   = 3;
    localparam int LETTER_I  = 8;
    localparam int LETTER_J  = 9;
    localparam int LETTER_Z  = 25;
    // row = (cell * 13) >> 6 is exact for every cell index below 25
    localparam int ROW_MUL   = 13;
    localparam int ROW_SHIFT = 6;

    typedef enum logic [1:0] {
        OP_KEY     = 2'd0,
        OP_FINISH  = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_DECRYPT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_READY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
    } t_item;

    typedef struct packed {
        logic [LETTER_W-1:0] out_a;
        logic [LETTER_W-1:0] out_b;
        t_status             status;
    } t_result;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_coord;

    typedef struct packed {
        logic [CELL_W-1:0] cell_a;
        logic [CELL_W-1:0] cell_b;
    } t_cells;

    // Clamp codes above z to z and take j as i.
    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] c;
        c = v;
        if (c > LETTER_W'(LETTER_Z)) c = LETTER_W'(LETTER_Z);
        if (c == LETTER_W'(LETTER_J)) c = LETTER_W'(LETTER_I);
        return c;
    endfunction

    // Add a shift of 0..4 to a coordinate of 0..4, wrapping at the side length.
    function automatic logic [COORD_W-1:0] wrap_add(input logic [COORD_W-1:0] v,
                                                    input logic [COORD_W-1:0] s);
        logic [COORD_W:0] sum;
        sum = {1'b0, v} + {1'b0, s};
        if (sum >= (COORD_W+1)'(SIDE)) sum = sum - (COORD_W+1)'(SIDE);
        return sum[COORD_W-1:0];
    endfunction

    // Flatten row and column into a row-major cell index.
    function automatic logic [CELL_W-1:0] cell_index(input t_coord c);
        return {c.row, 2'b00} + CELL_W'(c.row) + CELL_W'(c.col);
    endfunction

endpackage

// ----- rtl/pfc_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ----- rtl/pfc_lane.sv -----
// Lookup lane: split one letter's cell index into row and column.
module pfc_lane (
    input  logic [pfc_pkg::CELL_W-1:0] i_cell,
    output pfc_pkg::t_coord            o_coord
);

    localparam int PROD_W = pfc_pkg::CELL_W + 4;

    logic [PROD_W-1:0]          prod;
    logic [pfc_pkg::COORD_W-1:0] row;
    logic [pfc_pkg::CELL_W-1:0]  row_base;

    // divide by the side length through a reciprocal multiply
    assign prod     = PROD_W'(i_cell) * PROD_W'(pfc_pkg::ROW_MUL);
    assign row      = pfc_pkg::COORD_W'(prod >> pfc_pkg::ROW_SHIFT);
    assign row_base = {row, 2'b00} + pfc_pkg::CELL_W'(row);

    assign o_coord.row = row;
    assign o_coord.col = pfc_pkg::COORD_W'(i_cell - row_base);

endmodule

// ----- rtl/pfc_merge.sv -----
// Merge stage: combine both lanes' coordinates into the two output cells.
module pfc_merge (
    input  pfc_pkg::t_coord i_lane_a,
    input  pfc_pkg::t_coord i_lane_b,
    input  logic            i_decrypt,
    output pfc_pkg::t_cells o_cells
);

    logic [pfc_pkg::COORD_W-1:0] step;
    pfc_pkg::t_coord             res_a;
    pfc_pkg::t_coord             res_b;

    // shift forward on encrypt, backward (side minus one) on decrypt
    assign step = i_decrypt ? pfc_pkg::COORD_W'(pfc_pkg::SIDE - 1) : pfc_pkg::COORD_W'(1);

    always_comb begin
        res_a = i_lane_a;
        res_b = i_lane_b;
        if (i_lane_a.row == i_lane_b.row) begin
            res_a.col = pfc_pkg::wrap_add(i_lane_a.col, step);
            res_b.col = pfc_pkg::wrap_add(i_lane_b.col, step);
        end else if (i_lane_a.col == i_lane_b.col) begin
            res_a.row = pfc_pkg::wrap_add(i_lane_a.row, step);
            res_b.row = pfc_pkg::wrap_add(i_lane_b.row, step);
        end else begin
            // swap the rectangle's corners
            res_a.col = i_lane_b.col;
            res_b.col = i_lane_a.col;
        end
    end

    assign o_cells.cell_a = pfc_pkg::cell_index(res_a);
    assign o_cells.cell_b = pfc_pkg::cell_index(res_b);

endmodule

// ----- rtl/playfair_pair_cipher.sv -----
// Top level of the Playfair pair cipher engine.
// Playfair cipher on letters coded 0 (a) to 25 (z); j is taken as i and codes
// above z as z. Raise start with an item while busy is low; the transaction is
// taken at that edge. Every item answers with exactly one result, shown on
// o_result for a single cycle while o_strobe is high; the receiver cannot hold
// it off, so capture it in that cycle. A key-letter item appends an unseen
// letter to the square and answers in the next cycle, with busy staying low,
// so key letters may stream one per cycle. A key letter on a finished square
// starts a new key. A finish item walks the 26 letters one per cycle to fill
// the free cells, holding busy meanwhile; it answers once z has been walked.
// An encrypt or decrypt pair holds busy until it answers: the accept edge reads
// both letter positions from the position memory, then the two lookup lanes
// and the merge stage form both target cells and read them from the square
// memory, then the result is registered and presented. A pair sent before the
// square is finished answers status 2 in the next cycle and changes nothing.
module playfair_pair_cipher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pfc_pkg::t_item   i_item,
    output logic             o_strobe,
    output pfc_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CELL,
        S_FILL
    } t_state;

    localparam int FILL_W = pfc_pkg::CELL_W;

    t_state                          r_state, n_state;
    logic [pfc_pkg::LETTERS-1:0]     r_used, n_used;
    logic [FILL_W-1:0]               r_fill, n_fill;
    logic                            r_ready, n_ready;
    logic [pfc_pkg::LETTER_W-1:0]    r_walk, n_walk;
    logic                            r_decrypt, n_decrypt;
    logic                            r_strobe, n_strobe;
    pfc_pkg::t_result                r_result, n_result;

    logic [pfc_pkg::LETTER_W-1:0]    fold_a;
    logic [pfc_pkg::LETTER_W-1:0]    fold_b;
    logic [FILL_W-1:0]               fill_eff;
    logic [pfc_pkg::LETTERS-1:0]     used_eff;

    logic                            place_en;
    logic [pfc_pkg::LETTER_W-1:0]    place_letter;
    logic [FILL_W-1:0]               place_cell;

    logic [pfc_pkg::CELL_W-1:0]      pos_a;
    logic [pfc_pkg::CELL_W-1:0]      pos_b;
    logic [pfc_pkg::LETTER_W-1:0]    sq_a;
    logic [pfc_pkg::LETTER_W-1:0]    sq_b;
    pfc_pkg::t_coord                 lane_a;
    pfc_pkg::t_coord                 lane_b;
    pfc_pkg::t_cells                 cells;

    assign fold_a = pfc_pkg::fold_letter(i_item.letter_a);
    assign fold_b = pfc_pkg::fold_letter(i_item.letter_b);

    // a key letter on a finished square sees an empty square
    assign fill_eff = r_ready ? '0 : r_fill;
    assign used_eff = r_ready ? '0 : r_used;

    // letter -> cell index; read both pair letters at the accept edge
    pfc_ram #(
        .WIDTH (pfc_pkg::CELL_W),
        .DEPTH (pfc_pkg::LETTERS)
    ) u_pos_ram (
        .i_clk    (i_clk),
        .i_we     (place_en),
        .i_waddr  (place_letter),
        .i_wdata  (place_cell),
        .i_raddr0 (fold_a),
        .i_raddr1 (fold_b),
        .o_rdata0 (pos_a),
        .o_rdata1 (pos_b)
    );

    // one lane per pair letter
    pfc_lane u_lane_a (
        .i_cell  (pos_a),
        .o_coord (lane_a)
    );

    pfc_lane u_lane_b (
        .i_cell  (pos_b),
        .o_coord (lane_b)
    );

    pfc_merge u_merge (
        .i_lane_a (lane_a),
        .i_lane_b (lane_b),
        .i_decrypt(r_decrypt),
        .o_cells  (cells)
    );

    // cell index -> letter; read both target cells out of the merge stage
    pfc_ram #(
        .WIDTH (pfc_pkg::LETTER_W),
        .DEPTH (pfc_pkg::CELLS)
    ) u_square_ram (
        .i_clk    (i_clk),
        .i_we     (place_en),
        .i_waddr  (place_cell),
        .i_wdata  (place_letter),
        .i_raddr0 (cells.cell_a),
        .i_raddr1 (cells.cell_b),
        .o_rdata0 (sq_a),
        .o_rdata1 (sq_b)
    );

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_ready      = r_ready;
        n_walk       = r_walk;
        n_decrypt    = r_decrypt;
        n_strobe     = 1'b0;
        n_result     = r_result;
        place_en     = 1'b0;
        place_letter = fold_a;
        place_cell   = fill_eff;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.operation)
                        pfc_pkg::OP_KEY: begin
                            // drop the old square on a new key, then append
                            n_ready         = 1'b0;
                            n_used          = used_eff;
                            n_fill          = fill_eff;
                            n_strobe        = 1'b1;
                            n_result.out_a  = '0;
                            n_result.out_b  = '0;
                            n_result.status = pfc_pkg::ST_DONE;
                            if (used_eff[fold_a] || fill_eff >= FILL_W'(pfc_pkg::CELLS)) begin
                                n_result.status = pfc_pkg::ST_PRESENT;
                            end else begin
                                place_en       = 1'b1;
                                n_used[fold_a] = 1'b1;
                                n_fill         = fill_eff + FILL_W'(1);
                            end
                        end
                        pfc_pkg::OP_FINISH: begin
                            n_state = S_FILL;
                            n_walk  = '0;
                        end
                        pfc_pkg::OP_ENCRYPT, pfc_pkg::OP_DECRYPT: begin
                            if (r_ready) begin
                                n_state   = S_LOOK;
                                n_decrypt = (i_item.operation == pfc_pkg::OP_DECRYPT);
                            end else begin
                                n_strobe        = 1'b1;
                                n_result.out_a  = '0;
                                n_result.out_b  = '0;
                                n_result.status = pfc_pkg::ST_NOT_READY;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                // positions are out of memory; lanes and merge address the square
                n_state = S_CELL;
            end
            S_CELL: begin
                n_state         = S_IDLE;
                n_strobe        = 1'b1;
                n_result.out_a  = sq_a;
                n_result.out_b  = sq_b;
                n_result.status = pfc_pkg::ST_DONE;
            end
            S_FILL: begin
                // place each unused letter but j in the next free cell
                place_letter = r_walk;
                place_cell   = r_fill;
                if (r_walk != pfc_pkg::LETTER_W'(pfc_pkg::LETTER_J) && !r_used[r_walk]
                    && r_fill < FILL_W'(pfc_pkg::CELLS)) begin
                    place_en       = 1'b1;
                    n_used[r_walk] = 1'b1;
                    n_fill         = r_fill + FILL_W'(1);
                end
                if (r_walk == pfc_pkg::LETTER_W'(pfc_pkg::LETTER_Z)) begin
                    n_state         = S_IDLE;
                    n_ready         = 1'b1;
                    n_strobe        = 1'b1;
                    n_result.out_a  = '0;
                    n_result.out_b  = '0;
                    n_result.status = pfc_pkg::ST_DONE;
                end else begin
                    n_walk = r_walk + pfc_pkg::LETTER_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_fill   <= '0;
            r_ready  <= 1'b0;
            r_walk   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_fill   <= n_fill;
            r_ready  <= n_ready;
            r_walk   <= n_walk;
            r_strobe <= n_strobe;
        end
        r_decrypt <= n_decrypt;
        r_result  <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(pfc_pkg::CELLS))
        else $error("fill count beyond square size");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_fill == FILL_W'(pfc_pkg::CELLS) && !r_used[pfc_pkg::LETTER_J]))
        else $error("finished square is not full");

    a_pair_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && r_ready && (i_item.operation == pfc_pkg::OP_ENCRYPT
            || i_item.operation == pfc_pkg::OP_DECRYPT)) |-> ##3 o_strobe)
        else $error("pair result not delivered on time");

    a_fill_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL || r_state == S_LOOK) |-> !r_strobe)
        else $error("result strobe while a transaction is in progress");
`endif

endmodule
